### rtl/dsa_pkg.sv
`timescale 1ns / 1ps
package dsa_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int CAP_W     = 11;
  localparam int DSIZE_W   = 12;
  localparam int ADDR_W    = 64;
  localparam int IDX_OUT_W = 10;
  localparam int LIVE_W    = 11;
  localparam int APB_AW    = 6;
  localparam int APB_DW    = 64;

  localparam logic [CAP_W-1:0]   CAPACITY_RST = 11'd1024;
  localparam logic [DSIZE_W-1:0] DSIZE_RST    = 12'd32;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_CAPACITY   = 3'd0,
    REG_DSIZE      = 3'd1,
    REG_CPU_BASE   = 3'd2,
    REG_GPU_BASE   = 3'd3,
    REG_SHADER_VIS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CAP_W-1:0]   capacity;
    logic [DSIZE_W-1:0] dsize;
    logic [ADDR_W-1:0]  cpu_base;
    logic [ADDR_W-1:0]  gpu_base;
    logic               shader_visible;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic                 grant;
    logic [IDX_OUT_W-1:0] index;
    logic [LIVE_W-1:0]    live;
  } result_t;

endpackage

### rtl/dsa_cfg_regs.sv
`timescale 1ns / 1ps
module dsa_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsa_pkg::APB_AW-1:0]  paddr,
  input  logic [dsa_pkg::APB_DW-1:0]  pwdata,
  output logic [dsa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output dsa_pkg::cfg_t               cfg
);
  import dsa_pkg::*;

  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = reg_idx_t'(paddr[APB_AW-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity       <= CAPACITY_RST;
      cfg.dsize          <= DSIZE_RST;
      cfg.cpu_base       <= '0;
      cfg.gpu_base       <= '0;
      cfg.shader_visible <= 1'b0;
    end else if (wr_en) begin
      case (sel)
        REG_CAPACITY:   cfg.capacity       <= pwdata[CAP_W-1:0];
        REG_DSIZE:      cfg.dsize          <= pwdata[DSIZE_W-1:0];
        REG_CPU_BASE:   cfg.cpu_base       <= pwdata[ADDR_W-1:0];
        REG_GPU_BASE:   cfg.gpu_base       <= pwdata[ADDR_W-1:0];
        REG_SHADER_VIS: cfg.shader_visible <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_CAPACITY:   prdata = APB_DW'(cfg.capacity);
      REG_DSIZE:      prdata = APB_DW'(cfg.dsize);
      REG_CPU_BASE:   prdata = APB_DW'(cfg.cpu_base);
      REG_GPU_BASE:   prdata = APB_DW'(cfg.gpu_base);
      REG_SHADER_VIS: prdata = APB_DW'(cfg.shader_visible);
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/dsa_slot_ctrl.sv
`timescale 1ns / 1ps
module dsa_slot_ctrl #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            accept,
  input  logic                                            opcode,
  input  logic [dsa_pkg::IDX_OUT_W-1:0]                   slot_index,
  input  dsa_pkg::cfg_t                                   cfg,
  output dsa_pkg::result_t                                res,
  output logic [$clog2(MAX_SLOTS)+dsa_pkg::DSIZE_W-1:0]   offset
);
  import dsa_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int OFF_W = IDX_W + DSIZE_W;

  // free stack and in-use marks; the in-use mark of an entry at or above hw is read but never used
  logic [IDX_W-1:0] stack_mem [MAX_SLOTS];
  logic             used_mem  [MAX_SLOTS];

  logic                 s1_valid;
  op_t                  s1_op;
  logic [IDX_OUT_W-1:0] s1_req;

  logic [CNT_W-1:0] top, top_next, hw, hw_next, cnt, cnt_next, lim;

  logic [IDX_W-1:0] stack_rd, stack_byp_data, stack_q, stack_raddr;
  logic [IDX_W-1:0] stack_waddr, stack_wdata;
  logic             stack_byp, stack_we;
  logic [IDX_W-1:0] used_raddr, used_waddr;
  logic             used_rd, used_byp, used_byp_data, used_q, used_we, used_wdata;

  logic [IDX_W-1:0] idx;
  logic [OFF_W-1:0] offset_next;
  logic             is_alloc, is_rel, pop_ok, bump_ok, alloc_ok, rel_ok, push_ok;
  result_t          res_next;

  always_comb begin
    if (32'(cfg.capacity) > 32'(MAX_SLOTS)) begin
      lim = CNT_W'(MAX_SLOTS);
    end else begin
      lim = CNT_W'(cfg.capacity);
    end
  end

  assign stack_q = stack_byp ? stack_byp_data : stack_rd;
  assign used_q  = used_byp  ? used_byp_data  : used_rd;

  assign is_alloc = s1_valid && (s1_op == OP_ALLOC);
  assign is_rel   = s1_valid && (s1_op == OP_RELEASE);
  assign pop_ok   = (top != '0);
  assign bump_ok  = (hw < lim);
  assign idx      = pop_ok ? stack_q : IDX_W'(hw);
  assign alloc_ok = is_alloc && (pop_ok || bump_ok);
  assign rel_ok   = is_rel && (32'(s1_req) < 32'(hw)) && used_q;
  assign push_ok  = rel_ok && (top < CNT_W'(MAX_SLOTS));

  // memory write side
  assign used_we     = alloc_ok || rel_ok;
  assign used_waddr  = alloc_ok ? idx : IDX_W'(s1_req);
  assign used_wdata  = alloc_ok;
  assign stack_we    = push_ok;
  assign stack_waddr = IDX_W'(top);
  assign stack_wdata = IDX_W'(s1_req);

  always_comb begin
    top_next = top;
    if (alloc_ok && pop_ok) begin
      top_next = top - CNT_W'(1);
    end else if (push_ok) begin
      top_next = top + CNT_W'(1);
    end
  end

  assign hw_next = (alloc_ok && !pop_ok) ? hw + CNT_W'(1) : hw;

  always_comb begin
    cnt_next = cnt;
    if (alloc_ok) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (rel_ok && (cnt != '0)) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  // read for the incoming request against the state it will see
  assign stack_raddr = IDX_W'(top_next - CNT_W'(1));
  assign used_raddr  = IDX_W'(slot_index);

  always_comb begin
    res_next.valid = s1_valid;
    if (is_alloc) begin
      res_next.status = alloc_ok ? ST_DONE : ST_FULL;
    end else begin
      res_next.status = rel_ok ? ST_DONE : ST_INVALID;
    end
    res_next.grant = alloc_ok;
    res_next.index = alloc_ok ? IDX_OUT_W'(idx) : '0;
    res_next.live  = LIVE_W'(cnt_next);
  end

  assign offset_next = OFF_W'(idx) * OFF_W'(cfg.dsize);

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rd       <= stack_mem[stack_raddr];
    stack_byp      <= stack_we && (stack_waddr == stack_raddr);
    stack_byp_data <= stack_wdata;
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    used_rd       <= used_mem[used_raddr];
    used_byp      <= used_we && (used_waddr == used_raddr);
    used_byp_data <= used_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      top       <= '0;
      hw        <= '0;
      cnt       <= '0;
      res.valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      top      <= top_next;
      hw       <= hw_next;
      cnt      <= cnt_next;
      res      <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_op  <= op_t'(opcode);
    s1_req <= slot_index;
    offset <= offset_next;
  end

endmodule

### rtl/dsa_addr_gen.sv
`timescale 1ns / 1ps
module dsa_addr_gen #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  dsa_pkg::cfg_t                                   cfg,
  input  dsa_pkg::result_t                                res,
  input  logic [$clog2(MAX_SLOTS)+dsa_pkg::DSIZE_W-1:0]   offset,
  output logic                                            done,
  output logic [1:0]                                      status,
  output logic [dsa_pkg::IDX_OUT_W-1:0]                   granted_index,
  output logic [dsa_pkg::ADDR_W-1:0]                      cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]                      gpu_address,
  output logic [dsa_pkg::LIVE_W-1:0]                      live_count
);
  import dsa_pkg::*;

  logic [ADDR_W-1:0] off64;

  assign off64 = ADDR_W'(offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  // zero both addresses unless a slot was granted; the GPU address is also zero when not shader visible
  always_ff @(posedge clk) begin
    status        <= res.status;
    granted_index <= res.index;
    live_count    <= res.live;
    cpu_address   <= res.grant ? cfg.cpu_base + off64 : '0;
    gpu_address   <= (res.grant && cfg.shader_visible) ? cfg.gpu_base + off64 : '0;
  end

endmodule

### rtl/descriptor_slot_allocator_core.sv
`timescale 1ns / 1ps
// Descriptor slot allocator: hands out and takes back slot indices of a fixed
// table of equal-sized descriptors.
// Request channel: drive opcode (allocate or release) and slot_index with
// start high; the request is taken at a rising edge where start is high and
// busy is low. busy drops at the first edge that sees reset released and stays
// low after that, so one request can be taken on every clock cycle.
// Result channel: each request yields exactly one result, shown on status,
// granted_index, cpu_address, gpu_address and live_count for one cycle with
// done high. A request's result passes through the request register, the result
// register and the output register, and results come in request order.
// The receiver cannot stall, so capture results whenever done is high.
// The pipeline has three register stages: the free-stack and in-use memory
// read, the allocate/release decision with the index times size product, and
// the base address add. Back-to-back requests see each other's updates
// through write-to-read forwarding on both memories.
// Configuration: APB-style port, registers at byte addresses 8*i (capacity,
// descriptor size, CPU base, GPU base, shader visibility). Write only while
// no request is in flight.
// Reset: clear stack pointer, bump pointer, live count and result strobe, and
// restore register defaults; busy holds high through reset, then drops.
module descriptor_slot_allocator_core #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [dsa_pkg::IDX_OUT_W-1:0] slot_index,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [dsa_pkg::IDX_OUT_W-1:0] granted_index,
  output logic [dsa_pkg::ADDR_W-1:0]   cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]   gpu_address,
  output logic [dsa_pkg::LIVE_W-1:0]   live_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsa_pkg::APB_AW-1:0]   paddr,
  input  logic [dsa_pkg::APB_DW-1:0]   pwdata,
  output logic [dsa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import dsa_pkg::*;

  localparam int OFF_W = $clog2(MAX_SLOTS) + DSIZE_W;

  cfg_t             cfg;
  result_t          res;
  logic [OFF_W-1:0] offset;
  logic             accept;

  // hold busy through reset, drop it once reset is released
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  dsa_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dsa_slot_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_slot_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (opcode),
    .slot_index (slot_index),
    .cfg        (cfg),
    .res        (res),
    .offset     (offset)
  );

  dsa_addr_gen #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_addr_gen (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .res           (res),
    .offset        (offset),
    .done          (done),
    .status        (status),
    .granted_index (granted_index),
    .cpu_address   (cpu_address),
    .gpu_address   (gpu_address),
    .live_count    (live_count)
  );

endmodule

### rtl/dsa_checker.sv
`timescale 1ns / 1ps
module dsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          opcode,
  input logic                          done,
  input logic [1:0]                    status,
  input logic [dsa_pkg::IDX_OUT_W-1:0] granted_index,
  input logic [dsa_pkg::ADDR_W-1:0]    cpu_address,
  input logic [dsa_pkg::ADDR_W-1:0]    gpu_address
);
  import dsa_pkg::*;

  // every accepted request gives a result with done high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("request without result three cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##3 !done)
    else $error("result without a matching request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_DONE)) |->
      (granted_index == '0) && (cpu_address == '0) && (gpu_address == '0))
    else $error("failed request carries a slot or address");

  a_release: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_RELEASE)) |-> ##3
      ((status != ST_FULL) && (granted_index == '0) &&
       (cpu_address == '0) && (gpu_address == '0)))
    else $error("release result looks like an allocate");

endmodule

bind descriptor_slot_allocator_core dsa_checker u_dsa_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .opcode        (opcode),
  .done          (done),
  .status        (status),
  .granted_index (granted_index),
  .cpu_address   (cpu_address),
  .gpu_address   (gpu_address)
);
